// File: sv/dtq_pkg.sv
// Shared constants, operation and status codes and control types of the task deque.
package dtq_pkg;

	localparam int QUEUE_DEPTH  = 256;
	localparam int IDX_W        = $clog2(QUEUE_DEPTH);
	localparam int CNT_W        = IDX_W + 1;
	localparam int HANDLE_WIDTH = 32;
	localparam int TASK_W       = 32;
	localparam int OCC_W        = 9;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_PUSH_BACK  = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_BACK   = 2'd3
	} dtq_op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} dtq_status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic exec;      // a request is taken this cycle
		logic load_out;  // move the finished result into the output register
	} dtq_cmd_t;

endpackage

// File: sv/double_ended_task_queue_core.sv
// Top level of the task deque: controller and datapath.
// A request taken in S_IDLE starts the registered store read and moves the controller to S_READ;
// from S_READ the result is loaded into the output register (out_valid high), and a stalled output delays the load.
// A new request is taken only in S_IDLE, so not while the previous one is still in S_READ.
// A finished result waits in the output register while the next request is taken.
// Reset (arst_n low, asynchronous) empties the queue; the handle store is not cleared.
module double_ended_task_queue_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [1:0]                 op,
	input  logic [dtq_pkg::TASK_W-1:0] task_in,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [dtq_pkg::TASK_W-1:0] task_out,
	output logic                       got_task,
	output logic [1:0]                 status,
	output logic [dtq_pkg::OCC_W-1:0]  occupancy
);
	import dtq_pkg::*;

	dtq_cmd_t cmd;

	dtq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	dtq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.task_in   (task_in),
		.task_out  (task_out),
		.got_task  (got_task),
		.status    (status),
		.occupancy (occupancy)
	);

endmodule

// File: sv/dtq_ctrl.sv
// Controller of the task deque: request sequencing and output handshake.
module dtq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	output logic             out_valid,
	input  logic             out_stall,
	output dtq_pkg::dtq_cmd_t cmd
);
	import dtq_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_READ
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	// Take a request whenever idle; a finished result waits in S_READ for a free output
	assign in_stall     = (state_q != S_IDLE);
	assign accept       = in_valid && !in_stall;
	assign out_free     = !out_valid_q || !out_stall;
	assign cmd.exec     = accept;
	assign cmd.load_out = (state_q == S_READ) && out_free;
	assign out_valid    = out_valid_q;

	// State and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) state_q <= S_READ;
				end
				S_READ: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: sv/dtq_datapath.sv
// Datapath of the task deque: ring store, end indices, count and result register.
module dtq_datapath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  dtq_pkg::dtq_cmd_t                 cmd,
	input  logic [1:0]                        op,
	input  logic [dtq_pkg::TASK_W-1:0]        task_in,
	output logic [dtq_pkg::TASK_W-1:0]        task_out,
	output logic                              got_task,
	output logic [1:0]                        status,
	output logic [dtq_pkg::OCC_W-1:0]         occupancy
);
	import dtq_pkg::*;

	logic [HANDLE_WIDTH-1:0] store_q [QUEUE_DEPTH];
	logic [IDX_W-1:0]        front_q;
	logic [IDX_W-1:0]        back_q;
	logic [CNT_W-1:0]        count_q;
	logic [HANDLE_WIDTH-1:0] rd_data_q;
	logic                    got_pend_q;
	dtq_status_t             st_pend_q;
	logic [TASK_W-1:0]       task_out_q;
	logic                    got_out_q;
	dtq_status_t             st_out_q;
	logic [OCC_W-1:0]        occ_out_q;

	dtq_op_t          op_e;
	logic             is_push;
	logic             full;
	logic             empty;
	logic             do_push;
	logic             do_pop;
	logic [IDX_W-1:0] front_dec;
	logic [IDX_W-1:0] front_inc;
	logic [IDX_W-1:0] back_dec;
	logic [IDX_W-1:0] back_inc;
	logic [IDX_W-1:0] wr_addr;
	logic [IDX_W-1:0] rd_addr;

	// Decode and end-index arithmetic (indices wrap naturally)
	assign op_e      = dtq_op_t'(op);
	assign is_push   = (op_e == OP_PUSH_FRONT) || (op_e == OP_PUSH_BACK);
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign empty     = (count_q == '0);
	assign do_push   = cmd.exec && is_push && !full;
	assign do_pop    = cmd.exec && !is_push && !empty;
	assign front_dec = front_q - 1'b1;
	assign front_inc = front_q + 1'b1;
	assign back_dec  = back_q - 1'b1;
	assign back_inc  = back_q + 1'b1;
	assign wr_addr   = (op_e == OP_PUSH_FRONT) ? front_dec : back_q;
	assign rd_addr   = (op_e == OP_POP_FRONT) ? front_q : back_dec;

	// Indices and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			back_q  <= '0;
			count_q <= '0;
		end else if (do_push) begin
			count_q <= count_q + 1'b1;
			if (op_e == OP_PUSH_FRONT) front_q <= front_dec;
			else back_q <= back_inc;
		end else if (do_pop) begin
			count_q <= count_q - 1'b1;
			if (op_e == OP_POP_FRONT) front_q <= front_inc;
			else back_q <= back_dec;
		end
	end

	// Handle store: one write or one registered read per request
	always_ff @(posedge clk) begin
		if (do_push) store_q[wr_addr] <= task_in[HANDLE_WIDTH-1:0];
		if (do_pop) rd_data_q <= store_q[rd_addr];
	end

	// Outcome of the request, held until the read data arrives
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			got_pend_q <= !is_push && !empty;
			if (is_push) st_pend_q <= full ? ST_FULL : ST_OK;
			else st_pend_q <= empty ? ST_EMPTY : ST_OK;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			task_out_q <= got_pend_q ? TASK_W'(rd_data_q) : '0;
			got_out_q  <= got_pend_q;
			st_out_q   <= st_pend_q;
			occ_out_q  <= OCC_W'(count_q);
		end
	end

	assign task_out  = task_out_q;
	assign got_task  = got_out_q;
	assign status    = st_out_q;
	assign occupancy = occ_out_q;

endmodule

// File: sv/dtq_checker.sv
// Port-level checks of the task deque and their binding to the top level.
module dtq_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [1:0]                 op,
	input logic [dtq_pkg::TASK_W-1:0] task_in,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [dtq_pkg::TASK_W-1:0] task_out,
	input logic                       got_task,
	input logic [1:0]                 status,
	input logic [dtq_pkg::OCC_W-1:0]  occupancy
);
	import dtq_pkg::*;

	// A stalled result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(task_out) && $stable(status))
		else $error("stalled result changed");

	// The block is busy in the cycle after taking a request
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("request taken back to back");

	// A returned handle only comes with ok status
	a_got_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && got_task |-> status == ST_OK)
		else $error("handle returned with error status");

	// Empty pops return nothing and report an empty queue
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == ST_EMPTY |-> !got_task && task_out == '0 && occupancy == '0)
		else $error("empty pop returned data");

	// Occupancy never exceeds capacity
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> occupancy <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy above capacity");

endmodule

bind double_ended_task_queue_core dtq_checker u_dtq_checker (.*);

// File: tb/sv/tb_double_ended_task_queue_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for the task deque core: directed and random requests against a ring-buffer predictor.
module tb_double_ended_task_queue_core;
	import dtq_pkg::*;

	localparam int CLK_PERIOD   = 8;
	localparam int RESET_CYCLES = 9;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [63:0] HANDLE_MASK = (64'd1 << HANDLE_WIDTH) - 64'd1;

	typedef struct packed {
		logic [TASK_W-1:0] task_out;
		logic              got_task;
		dtq_status_t       status;
		logic [OCC_W-1:0]  occupancy;
	} deque_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [1:0]        op = OP_PUSH_FRONT;
	logic [TASK_W-1:0] task_in = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [TASK_W-1:0] task_out;
	logic              got_task;
	logic [1:0]        status;
	logic [OCC_W-1:0]  occupancy;

	// Predictor state: ring of handles, both ends and the fill count
	logic [TASK_W-1:0] shadow_slots [QUEUE_DEPTH];
	int unsigned       shadow_front = 0;
	int unsigned       shadow_back = 0;
	int unsigned       shadow_count = 0;
	deque_result_t     expected_results [$];

	int          error_count = 0;
	int          requests_sent = 0;
	int          results_checked = 0;
	int          full_drops = 0;
	int          empty_pops = 0;
	int unsigned peak_count = 0;
	bit          sender_gaps_on = 1'b0;
	bit          receiver_stalls_on = 1'b0;
	int unsigned stall_left = 0;
	int unsigned cycle_count = 0;

	double_ended_task_queue_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.task_in   (task_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.task_out  (task_out),
		.got_task  (got_task),
		.status    (status),
		.occupancy (occupancy)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	// Mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(6, 25);
	endfunction

	function automatic logic [TASK_W-1:0] pick_handle();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return '0;
		else if (r == 1)
			return '1;
		return $urandom();
	endfunction

	// Apply one request to the predictor and return what the core must answer
	function automatic deque_result_t deque_model_step(dtq_op_t req_op, logic [TASK_W-1:0] handle);
		deque_result_t res;
		logic [TASK_W-1:0] kept;
		res.task_out = '0;
		res.got_task = 1'b0;
		res.status = ST_OK;
		kept = handle & HANDLE_MASK[TASK_W-1:0];
		if (req_op == OP_PUSH_FRONT || req_op == OP_PUSH_BACK) begin
			if (shadow_count >= QUEUE_DEPTH) begin
				res.status = ST_FULL;
				full_drops++;
			end else begin
				if (req_op == OP_PUSH_FRONT) begin
					shadow_front = (shadow_front + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					shadow_slots[shadow_front] = kept;
				end else begin
					shadow_slots[shadow_back] = kept;
					shadow_back = (shadow_back + 1) % QUEUE_DEPTH;
				end
				shadow_count++;
			end
		end else begin
			if (shadow_count == 0) begin
				res.status = ST_EMPTY;
				empty_pops++;
			end else begin
				if (req_op == OP_POP_FRONT) begin
					res.task_out = shadow_slots[shadow_front];
					shadow_front = (shadow_front + 1) % QUEUE_DEPTH;
				end else begin
					shadow_back = (shadow_back + QUEUE_DEPTH - 1) % QUEUE_DEPTH;
					res.task_out = shadow_slots[shadow_back];
				end
				shadow_count--;
				res.got_task = 1'b1;
			end
		end
		if (shadow_count > peak_count)
			peak_count = shadow_count;
		res.occupancy = OCC_W'(shadow_count);
		return res;
	endfunction

	// Drive one request, hold it until taken, then log its expected result.
	// Valid stays high afterwards so back-to-back requests need no re-raise.
	task automatic send_request(input dtq_op_t req_op, input logic [TASK_W-1:0] handle);
		int gap;
		gap = sender_gaps_on ? pick_gap() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= req_op;
		task_in <= handle;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(deque_model_step(req_op, handle));
		requests_sent++;
	endtask

	// Stop sending and let every outstanding result come back
	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic test_pops_on_empty();
		send_request(OP_POP_FRONT, '1);
		send_request(OP_POP_BACK, '0);
		send_request(OP_PUSH_BACK, 32'h0000_0001);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, 32'h8000_0000);
		send_request(OP_POP_FRONT, 32'h5555_5555);
		wait_all_results();
	endtask

	// Mixed ends: a back pop must see handles that were pushed at the front
	task automatic test_both_ends();
		send_request(OP_PUSH_FRONT, '1);
		send_request(OP_PUSH_BACK, '0);
		send_request(OP_PUSH_FRONT, 32'hA5A5_A5A5);
		send_request(OP_PUSH_FRONT, 32'h8000_0000);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_PUSH_BACK, 32'h0000_0001);
		send_request(OP_POP_FRONT, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_BACK, '0);
		send_request(OP_POP_FRONT, '0);
		wait_all_results();
	endtask

	task automatic test_random_mix(input int count);
		repeat (count)
			send_request(dtq_op_t'($urandom_range(0, 3)), pick_handle());
	endtask

	// Push-heavy until full plus drops, then pop-heavy until empty plus empty pops
	task automatic test_fill_past_full();
		while (shadow_count < QUEUE_DEPTH) begin
			if ($urandom_range(0, 99) < 85)
				send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_handle());
			else
				send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_handle());
		end
		repeat (4)
			send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_handle());
		while (shadow_count > 0) begin
			if ($urandom_range(0, 99) < 85)
				send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_handle());
			else
				send_request($urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT, pick_handle());
		end
		repeat (3)
			send_request($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, pick_handle());
	endtask

	// Receiver stall pattern
	always @(posedge clk) begin
		if (receiver_stalls_on && stall_left == 0 && $urandom_range(0, 99) < 20)
			stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
		if (receiver_stalls_on && stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Compare each taken result with the oldest expectation
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				$display("%0t: unexpected result task_out %h status %0d", $time, task_out, status);
				error_count++;
			end else begin
				want = expected_results.pop_front();
				results_checked++;
				if (task_out !== want.task_out) begin
					$display("%0t: task_out expected %h actual %h", $time, want.task_out, task_out);
					error_count++;
				end
				if (got_task !== want.got_task) begin
					$display("%0t: got_task expected %b actual %b", $time, want.got_task, got_task);
					error_count++;
				end
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d", $time, want.status, status);
					error_count++;
				end
				if (occupancy !== want.occupancy) begin
					$display("%0t: occupancy expected %0d actual %0d", $time, want.occupancy,
						occupancy);
					error_count++;
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, expected_results.size());
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_pops_on_empty();
		test_both_ends();

		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		test_random_mix(300);
		// hold off until every outstanding result is back before filling it up
		wait_all_results();
		test_fill_past_full();

		// a stretch at full rate with no idling on either side
		sender_gaps_on = 1'b0;
		receiver_stalls_on = 1'b0;
		test_random_mix(150);

		sender_gaps_on = 1'b1;
		receiver_stalls_on = 1'b1;
		test_random_mix(150);

		wait_all_results();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Summary: %0d requests sent, %0d results checked, peak occupancy %0d",
			requests_sent, results_checked, peak_count);
		$display("Summary: %0d pushes dropped on a full queue, %0d pops on an empty queue",
			full_drops, empty_pops);
		if (error_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// File: sim.f
sv/dtq_pkg.sv
sv/dtq_ctrl.sv
sv/dtq_datapath.sv
sv/double_ended_task_queue_core.sv
sv/dtq_checker.sv
tb/sv/tb_double_ended_task_queue_core.sv
